[hdl/fei_pkg.sv]
// Package for the frame element integrator: command, mode and type codes,
// datapath widths and the divider control and status structs.
// No dependencies.
package fei_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam int QW   = 32;               // quotient width
  localparam int DVW  = COUNT_WIDTH + 1;  // divisor width (n + 1)
  localparam int DW   = 33 + COUNT_WIDTH; // dividend magnitude width
  localparam int PW   = DW + 1;           // signed product/total width
  localparam int STEP_W = $clog2(QW);

  localparam logic [1:0] CMD_INTEGRATE = 2'd0;
  localparam logic [1:0] CMD_ASSIGN    = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;

  localparam logic [2:0] MODE_SUM   = 3'd0;
  localparam logic [2:0] MODE_AVG   = 3'd1;
  localparam logic [2:0] MODE_OR    = 3'd2;
  localparam logic [2:0] MODE_FIRST = 3'd3;
  localparam logic [2:0] MODE_LAST  = 3'd4;

  localparam logic [2:0] TYPE_U8   = 3'd0;
  localparam logic [2:0] TYPE_S8   = 3'd1;
  localparam logic [2:0] TYPE_BOOL = 3'd2;
  localparam logic [2:0] TYPE_U16  = 3'd3;
  localparam logic [2:0] TYPE_S16  = 3'd4;
  localparam logic [2:0] TYPE_U32  = 3'd5;
  localparam logic [2:0] TYPE_S32  = 3'd6;
  localparam logic [2:0] TYPE_STR  = 3'd7;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hdl/fei_if.sv]
// Handshake interfaces for the input and result words of the integrator.
// Depends on nothing.
interface fei_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  mode;
  logic [2:0]  type_code;
  logic [31:0] stored_value;
  logic [31:0] new_value;
  logic        end_of_frame;

  modport source (output valid, command, mode, type_code, stored_value, new_value,
                  end_of_frame, input ready);
  modport sink (input valid, command, mode, type_code, stored_value, new_value,
                end_of_frame, output ready);
endinterface

interface fei_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic [15:0] frames_done;

  modport source (output valid, result_value, frames_done, input ready);
  modport sink (input valid, result_value, frames_done, output ready);
endinterface

[hdl/frame_element_integrator_unit.sv]
// Frame element integrator top level: sequencer, frame counter, type handling.
// Depends on fei_pkg, fei_in_if, fei_out_if and fei_div_unit.
//
// Each input word folds one frame element into its accumulated value by sum,
// running average, OR, keep first or keep last, wrapped to the element type,
// and returns one result word with the frame count after that word. Sum, OR,
// keep and command words register their result and then pass through S_FIN
// into the output register; the next word is taken once S_FIN has loaded it.
// A running average goes through S_MUL, which multiplies the stored value by
// the frame count, S_LOAD, which forms the signed total and starts the
// restoring divider, S_DIV, which waits for the quotient and signs and wraps
// it, and S_FIN, which loads the output register. One word is worked on at
// a time; a new word may be accepted while the previous result waits, and a
// stalled result then holds that word in its last step.
module frame_element_integrator_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  fei_in_if.sink         in_i,
  fei_out_if.source      out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [fei_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic logic [31:0] wrap_type(logic [2:0] t, logic [31:0] v);
    logic [31:0] r;
    case (t) inside
      fei_pkg::TYPE_BOOL: r = {31'b0, |v[7:0]};
      fei_pkg::TYPE_U8, fei_pkg::TYPE_S8, fei_pkg::TYPE_STR: r = {24'b0, v[7:0]};
      fei_pkg::TYPE_U16, fei_pkg::TYPE_S16: r = {16'b0, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] as_number(logic [2:0] t, logic [31:0] b);
    logic signed [32:0] r;
    case (t) inside
      fei_pkg::TYPE_S8:  r = {{25{b[7]}}, b[7:0]};
      fei_pkg::TYPE_S16: r = {{17{b[15]}}, b[15:0]};
      fei_pkg::TYPE_S32: r = {b[31], b};
      default:           r = {1'b0, b};
    endcase
    return r;
  endfunction

  function automatic logic [15:0] frames_sat(logic [fei_pkg::COUNT_WIDTH-1:0] c);
    logic [32:0] ce;
    ce = 33'(c);
    if (ce > 33'h0_FFFF) return 16'hFFFF;
    return ce[15:0];
  endfunction

  logic [2:0]                         state_q, state_d;
  logic [fei_pkg::COUNT_WIDTH-1:0]    cnt_q, cnt_d;
  logic [fei_pkg::COUNT_WIDTH-1:0]    n_q, n_d;
  logic signed [32:0]                 a_q, a_d, b_q, b_d;
  logic [2:0]                         t_q, t_d;
  logic signed [fei_pkg::PW-1:0]      prod_q, prod_d;
  logic                               neg_q, neg_d;
  logic [31:0]                        res_q, res_d;
  logic [15:0]                        fd_q, fd_d;
  logic                               out_valid_q, out_valid_d;
  logic [31:0]                        out_res_q, out_res_d;
  logic [15:0]                        out_fd_q, out_fd_d;

  logic                               in_fire;
  logic [31:0]                        sw, vw;
  logic                               need_div;
  logic [31:0]                        simple_res;
  logic signed [fei_pkg::PW-1:0]      total;
  logic [fei_pkg::PW-1:0]             mag;
  logic [31:0]                        q_signed;
  fei_pkg::div_ctrl_t                 div_ctrl;
  fei_pkg::div_stat_t                 div_stat;
  logic [fei_pkg::QW-1:0]             quotient;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign sw = wrap_type(in_i.type_code, in_i.stored_value);
  assign vw = wrap_type(in_i.type_code, in_i.new_value);

  always_comb begin
    need_div   = 1'b0;
    simple_res = sw;
    case (in_i.command)
      fei_pkg::CMD_INTEGRATE: begin
        case (in_i.mode)
          fei_pkg::MODE_SUM: begin
            if (in_i.type_code == fei_pkg::TYPE_STR) simple_res = sw;
            else if (in_i.type_code == fei_pkg::TYPE_BOOL) simple_res = {31'b0, |(sw | vw)};
            else simple_res = wrap_type(in_i.type_code, sw + vw);
          end
          fei_pkg::MODE_AVG: begin
            need_div = (in_i.type_code != fei_pkg::TYPE_STR);
          end
          fei_pkg::MODE_OR: begin
            if (in_i.type_code == fei_pkg::TYPE_STR) simple_res = sw;
            else simple_res = sw | vw;
          end
          fei_pkg::MODE_FIRST: begin
            simple_res = (cnt_q == '0) ? vw : sw;
          end
          default: begin
            simple_res = vw;
          end
        endcase
      end
      fei_pkg::CMD_ASSIGN: simple_res = vw;
      default:             simple_res = sw;
    endcase
  end

  assign total    = prod_q + fei_pkg::PW'(b_q);
  assign mag      = total[fei_pkg::PW-1] ? -total : total;
  assign q_signed = neg_q ? -quotient : quotient;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    a_d         = a_q;
    b_d         = b_q;
    t_d         = t_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    res_d       = res_q;
    fd_d        = fd_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_fd_d    = out_fd_q;
    div_ctrl    = '0;

    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d   = cnt_q;
          a_d   = as_number(in_i.type_code, sw);
          b_d   = as_number(in_i.type_code, vw);
          t_d   = in_i.type_code;
          res_d = simple_res;
          case (in_i.command)
            fei_pkg::CMD_INTEGRATE: begin
              if (in_i.end_of_frame && cnt_q != CNT_MAX) cnt_d = cnt_q + 1'b1;
            end
            fei_pkg::CMD_ASSIGN: cnt_d = fei_pkg::COUNT_WIDTH'(1);
            fei_pkg::CMD_CLEAR:  cnt_d = '0;
            default:             cnt_d = cnt_q;
          endcase
          fd_d    = frames_sat(cnt_d);
          state_d = need_div ? S_MUL : S_FIN;
        end
      end
      S_MUL: begin
        prod_d  = fei_pkg::PW'(a_q) * fei_pkg::PW'($signed({1'b0, n_q}));
        state_d = S_LOAD;
      end
      S_LOAD: begin
        neg_d          = total[fei_pkg::PW-1];
        div_ctrl.start = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          res_d   = wrap_type(t_q, q_signed);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          out_fd_d    = fd_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  fei_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .dividend_i (mag[fei_pkg::DW-1:0]),
    .divisor_i  (fei_pkg::DVW'(n_q) + 1'b1),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    a_q       <= a_d;
    b_q       <= b_d;
    t_q       <= t_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    res_q     <= res_d;
    fd_q      <= fd_d;
    out_res_q <= out_res_d;
    out_fd_q  <= out_fd_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q;
  assign out_o.frames_done  = out_fd_q;

endmodule

[hdl/fei_div_unit.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fei_pkg.
module fei_div_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fei_pkg::div_ctrl_t          ctrl_i,
  input  logic [fei_pkg::DW-1:0]      dividend_i,
  input  logic [fei_pkg::DVW-1:0]     divisor_i,
  output fei_pkg::div_stat_t          stat_o,
  output logic [fei_pkg::QW-1:0]      quotient_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [fei_pkg::STEP_W-1:0]  step_q, step_d;
  logic [fei_pkg::DVW-1:0]     rem_q, rem_d;
  logic [fei_pkg::QW-1:0]      quo_q, quo_d;
  logic [fei_pkg::DVW-1:0]     dvs_q, dvs_d;
  logic [fei_pkg::DVW:0]       shifted;
  logic [fei_pkg::DVW:0]       diff;
  logic                        ge;

  // remainder stays below the divisor, so the shifted value fits DVW + 1 bits
  assign shifted = {rem_q, quo_q[fei_pkg::QW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = ~diff[fei_pkg::DVW];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = dividend_i[fei_pkg::DW-1:fei_pkg::QW];
      quo_d  = dividend_i[fei_pkg::QW-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? diff[fei_pkg::DVW-1:0] : shifted[fei_pkg::DVW-1:0];
      quo_d  = {quo_q[fei_pkg::QW-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == fei_pkg::STEP_W'(fei_pkg::QW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

[test/frame_element_integrator_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for frame_element_integrator_unit: handshaked element words in,
// results predicted in-bench and compared in order. Depends on fei_pkg, fei_in_if,
// fei_out_if and the unit under test.
module frame_element_integrator_unit_tb;
  import fei_pkg::*;

  localparam logic [1:0] CMD_SPARE      = 2'd3;
  localparam logic [2:0] MODE_SPARE_TOP = 3'd7;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned HOLD_CYCLES   = 500;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned FRAME_RUN     = 30;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  mode;
    logic [2:0]  type_code;
    logic [31:0] stored_value;
    logic [31:0] new_value;
    logic        end_of_frame;
  } elem_word_t;

  typedef struct packed {
    logic [31:0] value;
    logic [15:0] frames;
  } fold_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  fei_in_if  word_in_if ();
  fei_out_if word_out_if ();

  frame_element_integrator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_in_if),
    .out_o  (word_out_if)
  );

  elem_word_t   drv_word  = '0;
  logic         drv_valid = 1'b0;
  logic         rx_ready  = 1'b0;
  elem_word_t   pending_words[$];
  fold_result_t awaited_results[$];
  logic [COUNT_WIDTH-1:0] frame_tally = '0;

  int unsigned send_idle_pct = 6;
  int unsigned recv_idle_pct = 68;
  int unsigned hold_left = 0;
  logic        hold_go   = 1'b0;
  logic        hold_ack  = 1'b0;
  int unsigned cycles = 0;
  int unsigned words_taken = 0, avg_words = 0, results_checked = 0;
  int unsigned mismatches = 0, saturated_hits = 0;

  assign word_in_if.valid        = drv_valid;
  assign word_in_if.command      = drv_word.command;
  assign word_in_if.mode         = drv_word.mode;
  assign word_in_if.type_code    = drv_word.type_code;
  assign word_in_if.stored_value = drv_word.stored_value;
  assign word_in_if.new_value    = drv_word.new_value;
  assign word_in_if.end_of_frame = drv_word.end_of_frame;
  assign word_out_if.ready       = rx_ready;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [31:0] trim(logic [2:0] t, logic [31:0] v);
    case (t)
      TYPE_BOOL:          return {31'd0, |v[7:0]};
      TYPE_U16, TYPE_S16: return {16'd0, v[15:0]};
      TYPE_U32, TYPE_S32: return v;
      default:            return {24'd0, v[7:0]};
    endcase
  endfunction

  function automatic longint as_number(logic [2:0] t, logic [31:0] bits);
    case (t)
      TYPE_S8:  return longint'($signed(bits[7:0]));
      TYPE_S16: return longint'($signed(bits[15:0]));
      TYPE_S32: return longint'($signed(bits));
      default:  return longint'({32'd0, bits});
    endcase
  endfunction

  // updates frame_tally as the unit does
  function automatic fold_result_t fold_element(elem_word_t w);
    logic [31:0] sw, vw, res;
    logic [2:0]  t;
    longint      total;
    fold_result_t r;
    t   = w.type_code;
    sw  = trim(t, w.stored_value);
    vw  = trim(t, w.new_value);
    res = sw;
    case (w.command)
      CMD_INTEGRATE: begin
        case (w.mode)
          MODE_SUM: begin
            if (t == TYPE_STR) res = sw;
            else if (t == TYPE_BOOL) res = {31'd0, |(sw | vw)};
            else res = trim(t, sw + vw);
          end
          MODE_AVG: begin
            if (t != TYPE_STR) begin
              total = as_number(t, sw) * longint'(frame_tally) + as_number(t, vw);
              total = total / (longint'(frame_tally) + 1);
              res = trim(t, total[31:0]);
            end
          end
          MODE_OR:    res = (t == TYPE_STR) ? sw : trim(t, sw | vw);
          MODE_FIRST: res = (frame_tally == '0) ? vw : sw;
          default:    res = vw;
        endcase
        if (w.end_of_frame && frame_tally != '1) frame_tally = frame_tally + 1'b1;
      end
      CMD_ASSIGN: begin
        res = vw;
        frame_tally = COUNT_WIDTH'(1);
      end
      CMD_CLEAR: begin
        res = sw;
        frame_tally = '0;
      end
      default: res = sw;
    endcase
    r.value  = res;
    r.frames = (frame_tally > 'hFFFF) ? 16'hFFFF : 16'(frame_tally);
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_valid <= 1'b0;
      drv_word  <= '0;
    end else begin
      if (drv_valid && word_in_if.ready) begin
        awaited_results.insert(awaited_results.size(), fold_element(drv_word));
        words_taken++;
        if (drv_word.command == CMD_INTEGRATE && drv_word.mode == MODE_AVG) avg_words++;
      end
      if (!drv_valid || word_in_if.ready) begin
        if (pending_words.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          drv_word  <= pending_words.pop_front();
          drv_valid <= 1'b1;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, triggered by toggling hold_go
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_ack  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_ack) begin
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_go;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (word_out_if.valid && rx_ready) check_result();
      rx_ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  task automatic check_result();
    fold_result_t want;
    if (word_out_if.frames_done == 16'hFFFF) saturated_hits++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result word: value %h frames %0d",
                 word_out_if.result_value, word_out_if.frames_done);
    end else begin
      want = awaited_results.pop_front();
      results_checked++;
      if (want.value !== word_out_if.result_value || want.frames !== word_out_if.frames_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected value %h frames %0d, got value %h frames %0d",
                   results_checked, want.value, want.frames,
                   word_out_if.result_value, word_out_if.frames_done);
      end
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("frame_element_integrator_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic queue_word(logic [1:0] cmd, logic [2:0] mode, logic [2:0] t,
                            logic [31:0] s, logic [31:0] v, logic eof);
    elem_word_t w;
    w.command      = cmd;
    w.mode         = mode;
    w.type_code    = t;
    w.stored_value = s;
    w.new_value    = v;
    w.end_of_frame = eof;
    pending_words.insert(pending_words.size(), w);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return ($urandom() & 32'hFFFF_FF00) | ($urandom_range(1, 0) ? 32'h80 : 32'h7F);
      5: return ($urandom() & 32'hFFFF_0000) | ($urandom_range(1, 0) ? 32'h8000 : 32'h7FFF);
      6: return $urandom_range(255, 0);
      7: return $urandom() & 32'hFFFF_FF00;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    if ($urandom_range(99, 0) < 35) return MODE_AVG;
    return 3'($urandom_range(MODE_SPARE_TOP, 0));
  endfunction

  // mostly whole frames, with commands and junk words sprinkled in
  task automatic random_stretch(int count);
    int made, len, roll;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(99, 0);
      if (roll < 4) begin
        queue_word(CMD_ASSIGN, pick_mode(), 3'($urandom_range(7, 0)), pick_value(),
                   pick_value(), 1'($urandom_range(1, 0)));
        made++;
      end else if (roll < 7) begin
        queue_word(CMD_CLEAR, pick_mode(), 3'($urandom_range(7, 0)), pick_value(),
                   pick_value(), 1'($urandom_range(1, 0)));
        made++;
      end else if (roll < 9) begin
        queue_word(CMD_SPARE, pick_mode(), 3'($urandom_range(7, 0)), pick_value(),
                   pick_value(), 1'($urandom_range(1, 0)));
        made++;
      end else if (roll < 14) begin
        queue_word(2'($urandom_range(3, 0)), 3'($urandom_range(7, 0)),
                   3'($urandom_range(7, 0)), $urandom(), $urandom(),
                   1'($urandom_range(1, 0)));
        made++;
      end else begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          queue_word(CMD_INTEGRATE, pick_mode(), 3'($urandom_range(7, 0)), pick_value(),
                     pick_value(), i == len - 1);
        made += len;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || drv_valid || awaited_results.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: count starts at zero
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_S32, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_FIRST, TYPE_U8,  32'h0000_0012, 32'hFFFF_FFAB, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_FIRST, TYPE_U16, 32'hABCD_1234, 32'h0000_5678, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_SUM,   TYPE_U8,  32'h0000_00FF, 32'h0000_0001, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_SUM,   TYPE_BOOL, 32'h0000_0100, 32'hFFFF_FF00, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_SUM,   TYPE_BOOL, 32'h0000_0000, 32'h0000_0001, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_OR,    TYPE_S16, 32'h0000_8000, 32'h0000_00FF, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_S8,  32'h0000_0080, 32'h0000_007F, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_S16, 32'h0000_FFFF, 32'h0000_FFFE, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_U32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_BOOL, 32'h0000_0001, 32'h0000_0000, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_SUM,   TYPE_STR, 32'h0000_0041, 32'h0000_0042, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_AVG,   TYPE_STR, 32'h0000_0041, 32'h0000_0042, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_OR,    TYPE_STR, 32'h0000_0041, 32'h0000_0042, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_FIRST, TYPE_STR, 32'h0000_0041, 32'h0000_0042, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_LAST,  TYPE_STR, 32'h0000_0041, 32'h0000_0042, 1'b0);
    for (int m = MODE_LAST + 1; m <= MODE_SPARE_TOP; m++)
      queue_word(CMD_INTEGRATE, 3'(m), TYPE_U32, 32'h1111_1111, 32'hFEDC_BA98, 1'b0);
    queue_word(CMD_ASSIGN, MODE_SUM, TYPE_S16, 32'hFFFF_FFFF, 32'h1234_5678, 1'b0);
    queue_word(CMD_CLEAR,  MODE_SUM, TYPE_U8,  32'h0000_ABCD, 32'hFFFF_FFFF, 1'b1);
    queue_word(CMD_SPARE,  MODE_AVG, TYPE_S32, 32'hDEAD_BEEF, 32'h0000_0000, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_U32, 32'h0000_0007, 32'h8000_0001, 1'b1);
    random_stretch(350);
    wait_drained();

    // stall the output while words keep coming
    send_idle_pct = 0;
    for (int i = 0; i < 40; i++)
      queue_word(CMD_INTEGRATE, pick_mode(), 3'($urandom_range(7, 0)), pick_value(),
                 pick_value(), 1'($urandom_range(1, 0)));
    hold_go = ~hold_go;
    wait_drained();

    send_idle_pct = 68;
    recv_idle_pct = 6;
    random_stretch(350);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stretch(350);

    // build up the frame count, then average at extreme operands and mix in other commands
    queue_word(CMD_CLEAR, MODE_SUM, TYPE_U32, 32'h0, 32'h0, 1'b0);
    for (int i = 0; i < FRAME_RUN; i++)
      queue_word(CMD_INTEGRATE, MODE_OR, TYPE_U8, $urandom(), $urandom(), 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_S32, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_S32, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_U32, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_S16, 32'h0000_8000, 32'h0000_7FFF, 1'b1);
    queue_word(CMD_INTEGRATE, MODE_FIRST, TYPE_S8, 32'h0000_0080, 32'h0000_007F, 1'b1);
    queue_word(CMD_SPARE, MODE_SUM, TYPE_U16, 32'h1234_5678, 32'h0, 1'b1);
    queue_word(CMD_ASSIGN, MODE_SUM, TYPE_U32, 32'h0, 32'hCAFE_F00D, 1'b0);
    queue_word(CMD_INTEGRATE, MODE_AVG, TYPE_S32, 32'hFFFF_FFFF, 32'h0000_0002, 1'b0);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("%0d words in, %0d results checked, %0d running averages, %0d at full count",
             words_taken, results_checked, avg_words, saturated_hits);
    $display("%0d mismatches, %0d results outstanding in %0d cycles",
             mismatches, awaited_results.size(), cycles);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("frame_element_integrator_unit_tb: done, clean");
    end else begin
      $display("frame_element_integrator_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
